// ===== sv/fraie_pkg.sv =====
// Types and constants for the four-register ALU interpreter.
// Used by fraie_iter_unit and four_register_alu_interpreter_core. No dependencies.
`default_nettype none

package fraie_pkg;

    localparam logic [2:0] FUNC_LOAD = 3'd0;
    localparam logic [2:0] FUNC_MOVE = 3'd1;
    localparam logic [2:0] FUNC_ADD  = 3'd2;
    localparam logic [2:0] FUNC_SUB  = 3'd3;
    localparam logic [2:0] FUNC_MUL  = 3'd4;
    localparam logic [2:0] FUNC_DIV  = 3'd5;
    localparam logic [2:0] FUNC_OUT  = 3'd6;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DIV_ZERO = 1'b1;

    typedef struct packed {
        logic [2:0]         func;
        logic [1:0]         dest_reg;
        logic [1:0]         src_reg;
        logic signed [31:0] immediate;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               status;
    } out_item_t;

    typedef enum logic [1:0] {
        UOP_ADD,
        UOP_SUB,
        UOP_MUL,
        UOP_DIV
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/four_register_alu_interpreter_core.sv =====
// After the input transfer, load/move write the register file in the dispatch state; add,
// sub, multiply and divide write when the shared iterative unit is done (multiply and divide
// take one bit per cycle); output and divide error go to the result reg. One item at a time:
// s_ready is high only between items; an output or divide-error item also waits while the
// result reg is full and m_ready is low. Synchronous active-low reset empties the output
// register and reads all registers as zero. Depends on fraie_pkg and fraie_iter_unit.
`default_nettype none

module four_register_alu_interpreter_core #(
    parameter int DATA_WIDTH = 32,
    parameter int NUM_REGS   = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire fraie_pkg::in_item_t  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output fraie_pkg::out_item_t      m_data
);

    localparam int IDX_W = $clog2(NUM_REGS);
    localparam logic [4:0] NUM_REGS_L = 5'(NUM_REGS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WAIT,
        ST_OUT
    } state_t;

    state_t                  state_reg;
    logic [2:0]              func_reg;
    logic [IDX_W-1:0]        dest_idx_reg;
    logic                    dest_ok_reg;
    logic signed [31:0]      imm_reg;
    logic [DATA_WIDTH-1:0]   a_data_reg;
    logic [DATA_WIDTH-1:0]   b_data_reg;
    logic                    a_ok_reg;
    logic                    b_ok_reg;
    fraie_pkg::out_item_t    pend_reg;
    logic                    m_valid_reg;
    fraie_pkg::out_item_t    m_data_reg;

    logic [DATA_WIDTH-1:0]   reg_mem [NUM_REGS];
    logic [NUM_REGS-1:0]     reg_valid_reg;

    logic                    s_xfer;
    logic [IDX_W-1:0]        a_idx;
    logic [IDX_W-1:0]        b_idx;
    logic                    a_in_range;
    logic                    b_in_range;
    logic [DATA_WIDTH-1:0]   a_val;
    logic [DATA_WIDTH-1:0]   b_val;
    logic                    b_zero;
    logic                    wr_en;
    logic [DATA_WIDTH-1:0]   wr_data;
    fraie_pkg::unit_ctrl_t   unit_ctrl;
    logic                    unit_done;
    logic [DATA_WIDTH-1:0]   unit_result;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_xfer     = s_valid && s_ready;
    assign a_idx      = IDX_W'(s_data.dest_reg);
    assign b_idx      = IDX_W'(s_data.src_reg);
    assign a_in_range = ({3'b000, s_data.dest_reg} < NUM_REGS_L);
    assign b_in_range = ({3'b000, s_data.src_reg} < NUM_REGS_L);
    assign a_val      = a_ok_reg ? a_data_reg : '0;
    assign b_val      = b_ok_reg ? b_data_reg : '0;
    assign b_zero     = (b_val == '0);

    // register file reads
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            a_data_reg <= reg_mem[a_idx];
            b_data_reg <= reg_mem[b_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            reg_mem[dest_idx_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reg_valid_reg <= '0;
        end else if (wr_en) begin
            reg_valid_reg[dest_idx_reg] <= 1'b1;
        end
    end

    always_comb begin
        unit_ctrl.start = 1'b0;
        unit_ctrl.op    = fraie_pkg::UOP_ADD;
        if (state_reg == ST_DISPATCH) begin
            unique case (func_reg)
                fraie_pkg::FUNC_ADD: begin
                    unit_ctrl.start = 1'b1;
                end
                fraie_pkg::FUNC_SUB: begin
                    unit_ctrl.start = 1'b1;
                    unit_ctrl.op    = fraie_pkg::UOP_SUB;
                end
                fraie_pkg::FUNC_MUL: begin
                    unit_ctrl.start = 1'b1;
                    unit_ctrl.op    = fraie_pkg::UOP_MUL;
                end
                fraie_pkg::FUNC_DIV: begin
                    unit_ctrl.start = !b_zero;
                    unit_ctrl.op    = fraie_pkg::UOP_DIV;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_data = unit_result;
        if (state_reg == ST_DISPATCH) begin
            if (func_reg == fraie_pkg::FUNC_LOAD) begin
                wr_en   = dest_ok_reg;
                wr_data = DATA_WIDTH'(imm_reg);
            end else if (func_reg == fraie_pkg::FUNC_MOVE) begin
                wr_en   = dest_ok_reg;
                wr_data = b_val;
            end
        end else if (state_reg == ST_WAIT) begin
            wr_en = dest_ok_reg && unit_done;
        end
    end

    fraie_iter_unit #(
        .W(DATA_WIDTH)
    ) u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl_i  (unit_ctrl),
        .a_i     (a_val),
        .b_i     (b_val),
        .done_o  (unit_done),
        .result_o(unit_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= pend_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        func_reg     <= s_data.func;
                        dest_idx_reg <= a_idx;
                        dest_ok_reg  <= a_in_range;
                        imm_reg      <= s_data.immediate;
                        a_ok_reg     <= a_in_range && reg_valid_reg[a_idx];
                        b_ok_reg     <= b_in_range && reg_valid_reg[b_idx];
                        state_reg    <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    unique case (func_reg) inside
                        fraie_pkg::FUNC_ADD, fraie_pkg::FUNC_SUB,
                        fraie_pkg::FUNC_MUL: begin
                            state_reg <= ST_WAIT;
                        end
                        fraie_pkg::FUNC_DIV: begin
                            if (b_zero) begin
                                pend_reg.value  <= '0;
                                pend_reg.status <= fraie_pkg::STATUS_DIV_ZERO;
                                state_reg       <= ST_OUT;
                            end else begin
                                state_reg <= ST_WAIT;
                            end
                        end
                        fraie_pkg::FUNC_OUT: begin
                            pend_reg.value  <= 32'(a_val);
                            pend_reg.status <= fraie_pkg::STATUS_OK;
                            state_reg       <= ST_OUT;
                        end
                        default: begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_WAIT: begin
                    if (unit_done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_done |-> state_reg == ST_WAIT)
        else $error("iter unit done outside wait state");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> state_reg != ST_IDLE)
        else $error("register write while idle");

    a_err_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == fraie_pkg::STATUS_DIV_ZERO) |-> m_data.value == '0)
        else $error("divide error result carries nonzero value");

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> state_reg == ST_DISPATCH)
        else $error("accepted transfer not dispatched");
`endif

endmodule

`default_nettype wire

// ===== sv/fraie_iter_unit.sv =====
// Shared iterative arithmetic unit: one adder/subtractor serves add, sub,
// shift-add multiply and restoring divide. Depends on fraie_pkg.
`default_nettype none

module fraie_iter_unit #(
    parameter int W = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire fraie_pkg::unit_ctrl_t ctrl_i,
    input  wire logic [W-1:0]          a_i,
    input  wire logic [W-1:0]          b_i,
    output logic                       done_o,
    output logic [W-1:0]               result_o
);

    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_NEGA,
        U_NEGB,
        U_DIV,
        U_NEGQ
    } ustate_t;

    ustate_t          state_reg;
    logic [W-1:0]     x_reg;
    logic [W-1:0]     y_reg;
    logic [W-1:0]     acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [W-1:0]     res_reg;
    logic             done_reg;

    logic [W:0]   add_x;
    logic [W:0]   add_y;
    logic [W:0]   add_sum;
    logic         add_sub;
    logic [W-1:0] mul_acc_next;
    logic         div_ge;
    logic [W-1:0] div_rem_next;

    // single shared adder
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            U_IDLE: begin
                add_x   = {1'b0, a_i};
                add_y   = {1'b0, b_i};
                add_sub = (ctrl_i.op == fraie_pkg::UOP_SUB);
            end
            U_MUL: begin
                add_x = {1'b0, acc_reg};
                add_y = {1'b0, x_reg};
            end
            U_NEGA: begin
                add_y   = {1'b0, x_reg};
                add_sub = 1'b1;
            end
            U_NEGB: begin
                add_y   = {1'b0, y_reg};
                add_sub = 1'b1;
            end
            U_DIV: begin
                add_x   = {acc_reg, x_reg[W-1]};
                add_y   = {1'b0, y_reg};
                add_sub = 1'b1;
            end
            U_NEGQ: begin
                add_y   = {1'b0, x_reg};
                add_sub = 1'b1;
            end
            default: begin
            end
        endcase
        add_sum = add_x + (add_sub ? ~add_y : add_y) + {{W{1'b0}}, add_sub};
    end

    assign mul_acc_next = y_reg[0] ? add_sum[W-1:0] : acc_reg;
    assign div_ge       = ~add_sum[W];
    assign div_rem_next = div_ge ? add_sum[W-1:0] : {acc_reg[W-2:0], x_reg[W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                U_IDLE: begin
                    if (ctrl_i.start) begin
                        unique case (ctrl_i.op) inside
                            fraie_pkg::UOP_ADD, fraie_pkg::UOP_SUB: begin
                                res_reg  <= add_sum[W-1:0];
                                done_reg <= 1'b1;
                            end
                            fraie_pkg::UOP_MUL: begin
                                x_reg     <= a_i;
                                y_reg     <= b_i;
                                acc_reg   <= '0;
                                cnt_reg   <= '0;
                                state_reg <= U_MUL;
                            end
                            fraie_pkg::UOP_DIV: begin
                                x_reg     <= a_i;
                                y_reg     <= b_i;
                                neg_reg   <= a_i[W-1] ^ b_i[W-1];
                                state_reg <= U_NEGA;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                U_MUL: begin
                    acc_reg <= mul_acc_next;
                    x_reg   <= x_reg << 1;
                    y_reg   <= y_reg >> 1;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_LAST) begin
                        res_reg   <= mul_acc_next;
                        done_reg  <= 1'b1;
                        state_reg <= U_IDLE;
                    end
                end
                U_NEGA: begin
                    if (x_reg[W-1]) begin
                        x_reg <= add_sum[W-1:0];
                    end
                    state_reg <= U_NEGB;
                end
                U_NEGB: begin
                    if (y_reg[W-1]) begin
                        y_reg <= add_sum[W-1:0];
                    end
                    acc_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= U_DIV;
                end
                U_DIV: begin
                    acc_reg <= div_rem_next;
                    x_reg   <= {x_reg[W-2:0], div_ge};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_LAST) begin
                        state_reg <= U_NEGQ;
                    end
                end
                U_NEGQ: begin
                    res_reg   <= neg_reg ? add_sum[W-1:0] : x_reg;
                    done_reg  <= 1'b1;
                    state_reg <= U_IDLE;
                end
                default: begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done_o   = done_reg;
    assign result_o = res_reg;

endmodule

`default_nettype wire
